FILE: sv/btt_pkg.sv
package btt_pkg;

    // Default sizes
    localparam int NODE_COUNT_DEF = 64;
    localparam int KEY_WIDTH_DEF  = 32;

    // Fixed field widths of the channels and of the stack phase
    localparam int IO_KEY_W = 32;
    localparam int IDX_W    = 6;
    localparam int CHILD_W  = 7;
    localparam int ORDER_W  = 2;
    localparam int PHASE_W  = 2;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_WALK = 1'b1;

    // Walk orders
    localparam logic [ORDER_W-1:0] ORDER_IN   = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_PRE  = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_POST = 2'd2;
    localparam logic [ORDER_W-1:0] ORDER_NONE = 2'd3;

    // Visit phase of a stack entry
    localparam logic [PHASE_W-1:0] PH_FIRST = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MID   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LAST  = 2'd2;

    // Walk sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_POP,
        S_DONE
    } t_state;

endpackage

FILE: sv/btt_if.sv
interface btt_in_if import btt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [IDX_W-1:0]           node_index;
    logic signed [IO_KEY_W-1:0] node_key;
    logic signed [CHILD_W-1:0]  left_child;
    logic signed [CHILD_W-1:0]  right_child;
    logic [ORDER_W-1:0]         walk_order;

    modport source (output valid, func, node_index, node_key, left_child, right_child,
                    walk_order, input ready);
    modport sink   (input valid, func, node_index, node_key, left_child, right_child,
                    walk_order, output ready);
endinterface

interface btt_out_if import btt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [IO_KEY_W-1:0] key_out;
    logic                       last;
    logic                       overrun;

    modport source (output valid, key_out, last, overrun, input ready);
    modport sink   (input valid, key_out, last, overrun, output ready);
endinterface

FILE: sv/binary_tree_traversal.sv
// Binary tree walker over a node table held in on-chip memory.
// Input channel i_in: func 0 loads one node (key, left and right child,
// -1 or any index at or above NODE_COUNT meaning no child); func 1 walks
// the tree from node 0 in in-order, pre-order or post-order (order 3 is
// dropped). Loads give no result.
// Output channel o_out: one item per visited key; the final one has last
// set, and overrun set when the walk was cut by the emit or stack limit
// (a walk cut before any key gives a single item with key 0).
// Without stalls a walk runs, per node, one node memory read (FETCH) and
// three phase steps (EXEC), and per return to a parent one stack memory
// read (POP) and a fresh node read (FETCH). The DONE state then hands out
// the final item, after which the next input item can be taken.
// The input is accepted only between walks; loads stream one per cycle.
// Output is registered; one further key waits in a holding stage, so the
// walk runs on while the receiver stalls and pauses only when both are full.
// Reset clears the sequencer, the stack pointer and the output valid;
// the node table keeps no reset value and must be loaded before a walk.
module binary_tree_traversal import btt_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btt_in_if.sink     i_in,
    btt_out_if.source  o_out
);

    localparam int KW  = (KEY_WIDTH < IO_KEY_W) ? KEY_WIDTH : IO_KEY_W;
    localparam int AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SPW = $clog2(NODE_COUNT + 1);
    localparam int CW  = $clog2(NODE_COUNT + 1);

    t_state r_state, n_state;

    logic [SPW-1:0]          r_sp, n_sp;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [ORDER_W-1:0]      r_order, n_order;
    logic [AW-1:0]           r_top_node, n_top_node;
    logic [PHASE_W-1:0]      r_top_ph, n_top_ph;
    logic                    r_over, n_over;
    logic                    r_pend_v, n_pend_v;
    logic [IO_KEY_W-1:0]     r_pend_key, n_pend_key;
    logic                    r_out_v, n_out_v;
    logic [IO_KEY_W-1:0]     r_out_key, n_out_key;
    logic                    r_out_last, n_out_last;
    logic                    r_out_ovr, n_out_ovr;

    // Stack memory: entries below the top, top kept in registers
    logic [PHASE_W+AW-1:0]   r_stk [NODE_COUNT];
    logic [PHASE_W+AW-1:0]   r_stk_rd;
    logic                    stk_wr_en, stk_rd_en;
    logic [AW-1:0]           stk_wr_addr, stk_rd_addr;
    logic [PHASE_W+AW-1:0]   stk_wr_data;

    // Node memory signals
    logic                    node_wr_en, node_rd_en;
    logic signed [KW-1:0]    rd_key;
    logic [CHILD_W-1:0]      rd_left, rd_right;

    logic                    in_acc, out_free, hit, emit_lim, stall;
    logic                    left_ok, right_ok, push, push_fail;
    logic [CHILD_W-1:0]      child;
    logic [SPW-1:0]          sp_m1, sp_m2;

    btt_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .KW         (KW),
        .AW         (AW)
    ) u_node_mem (
        .i_clk      (i_clk),
        .i_wr_en    (node_wr_en),
        .i_wr_addr  (i_in.node_index[AW-1:0]),
        .i_wr_key   (i_in.node_key[KW-1:0]),
        .i_wr_left  (i_in.left_child),
        .i_wr_right (i_in.right_child),
        .i_rd_en    (node_rd_en),
        .i_rd_addr  (r_top_node),
        .o_rd_key   (rd_key),
        .o_rd_left  (rd_left),
        .o_rd_right (rd_right)
    );

    // Decode the handshake and the current stack step
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_v || o_out.ready;
    assign node_wr_en = in_acc && (i_in.func == FUNC_LOAD) &&
                        ({1'b0, i_in.node_index} < CHILD_W'(NODE_COUNT));
    assign node_rd_en = (r_state == S_FETCH);

    assign hit = ((r_order == ORDER_PRE)  && (r_top_ph == PH_FIRST)) ||
                 ((r_order == ORDER_IN)   && (r_top_ph == PH_MID))   ||
                 ((r_order == ORDER_POST) && (r_top_ph == PH_LAST));
    assign emit_lim  = hit && (r_cnt >= CW'(NODE_COUNT));
    assign stall     = hit && !emit_lim && r_pend_v && !out_free;
    assign left_ok   = rd_left  < CHILD_W'(NODE_COUNT);
    assign right_ok  = rd_right < CHILD_W'(NODE_COUNT);
    assign push      = ((r_top_ph == PH_FIRST) && left_ok) ||
                       ((r_top_ph == PH_MID)   && right_ok);
    assign child     = (r_top_ph == PH_FIRST) ? rd_left : rd_right;
    assign push_fail = push && (r_sp >= SPW'(NODE_COUNT));
    assign sp_m1     = r_sp - SPW'(1);
    assign sp_m2     = r_sp - SPW'(2);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.func == FUNC_WALK) && (i_in.walk_order != ORDER_NONE)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!stall) begin
                    if (emit_lim || push_fail) begin
                        n_state = S_DONE;
                    end else if (push) begin
                        n_state = S_FETCH;
                    end else if (r_top_ph == PH_LAST) begin
                        n_state = (r_sp == SPW'(1)) ? S_DONE : S_POP;
                    end
                end
            end
            S_POP: begin
                n_state = S_FETCH;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_sp        = r_sp;
        n_cnt       = r_cnt;
        n_order     = r_order;
        n_top_node  = r_top_node;
        n_top_ph    = r_top_ph;
        n_over      = r_over;
        n_pend_v    = r_pend_v;
        n_pend_key  = r_pend_key;
        n_out_v     = r_out_v && !o_out.ready;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;
        n_out_ovr   = r_out_ovr;
        stk_wr_en   = 1'b0;
        stk_wr_addr = sp_m1[AW-1:0];
        stk_wr_data = {r_top_ph + PHASE_W'(1), r_top_node};
        stk_rd_en   = 1'b0;
        stk_rd_addr = sp_m2[AW-1:0];
        case (r_state)
            S_IDLE: begin
                // Start a walk at the root
                if (in_acc && (i_in.func == FUNC_WALK)) begin
                    n_sp       = SPW'(1);
                    n_cnt      = '0;
                    n_order    = i_in.walk_order;
                    n_top_node = '0;
                    n_top_ph   = PH_FIRST;
                    n_over     = 1'b0;
                end
            end
            S_EXEC: begin
                if (!stall) begin
                    // Emit the key; the held one moves to the output
                    if (hit && !emit_lim) begin
                        n_cnt      = r_cnt + CW'(1);
                        n_pend_v   = 1'b1;
                        n_pend_key = IO_KEY_W'(rd_key);
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_key  = r_pend_key;
                            n_out_last = 1'b0;
                            n_out_ovr  = 1'b0;
                        end
                    end
                    // Advance the stack
                    if (emit_lim || push_fail) begin
                        n_over = 1'b1;
                    end else if (push) begin
                        stk_wr_en  = 1'b1;
                        n_top_node = child[AW-1:0];
                        n_top_ph   = PH_FIRST;
                        n_sp       = r_sp + SPW'(1);
                    end else if (r_top_ph == PH_LAST) begin
                        n_sp      = sp_m1;
                        stk_rd_en = (r_sp != SPW'(1));
                    end else begin
                        n_top_ph = r_top_ph + PHASE_W'(1);
                    end
                end
            end
            S_POP: begin
                n_top_ph   = r_stk_rd[PHASE_W+AW-1:AW];
                n_top_node = r_stk_rd[AW-1:0];
            end
            S_DONE: begin
                // Hand out the final item
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_key  = r_pend_v ? r_pend_key : '0;
                    n_out_last = 1'b1;
                    n_out_ovr  = r_pend_v ? r_over : 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Stack memory
    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            r_stk[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en) begin
            r_stk_rd <= r_stk[stk_rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_cnt    <= '0;
            r_over   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_cnt    <= n_cnt;
            r_over   <= n_over;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_order    <= n_order;
        r_top_node <= n_top_node;
        r_top_ph   <= n_top_ph;
        r_pend_key <= n_pend_key;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
        r_out_ovr  <= n_out_ovr;
    end

    assign o_out.valid   = r_out_v;
    assign o_out.key_out = r_out_key;
    assign o_out.last    = r_out_last;
    assign o_out.overrun = r_out_ovr;

endmodule

FILE: sv/btt_node_mem.sv
module btt_node_mem import btt_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int KW         = KEY_WIDTH_DEF,
    parameter int AW         = 6
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [KW-1:0]             i_wr_key,
    input  logic [CHILD_W-1:0]        i_wr_left,
    input  logic [CHILD_W-1:0]        i_wr_right,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic signed [KW-1:0]      o_rd_key,
    output logic [CHILD_W-1:0]        o_rd_left,
    output logic [CHILD_W-1:0]        o_rd_right
);

    logic [KW+2*CHILD_W-1:0] r_mem [NODE_COUNT];
    logic [KW+2*CHILD_W-1:0] r_rd;

    // Write a node entry, read one with registered data held between reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_key, i_wr_left, i_wr_right};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd[KW+2*CHILD_W-1:2*CHILD_W];
    assign o_rd_left  = r_rd[2*CHILD_W-1:CHILD_W];
    assign o_rd_right = r_rd[CHILD_W-1:0];

endmodule
